// ===== hw/rtl/pct_pkg.sv =====
package pct_pkg;

	localparam int MaxPoints = 1024;
	localparam int PtW       = $clog2(MaxPoints);
	localparam int FillW     = $clog2(MaxPoints + 1);

	localparam int CfgAddrW = 2;
	localparam int CfgDataW = 32;
	localparam int InDataW  = 80;
	localparam int OutDataW = 224;
	localparam int TractW   = 48;
	localparam int SumW     = 42;
	localparam int CntW     = 11;
	localparam int RelaxW   = 17;

	localparam logic [CfgAddrW-1:0] CfgPenalty = 2'd0;
	localparam logic [CfgAddrW-1:0] CfgRelax   = 2'd1;
	localparam logic [CfgAddrW-1:0] CfgOffset  = 2'd2;

	localparam logic [31:0]       PenaltyReset = 32'd65536;
	localparam logic [RelaxW-1:0] RelaxReset   = 17'd1311;
	localparam logic [RelaxW-1:0] RelaxOne     = 17'd65536;
	localparam logic [CntW-1:0]   CountMax     = 11'd2047;

	localparam logic signed [TractW-1:0] TractMax = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [TractW-1:0] TractMin = 48'sh8000_0000_0000;
	localparam logic signed [SumW-1:0]   SumMax   = 42'sh1FF_FFFF_FFFF;
	localparam logic signed [SumW-1:0]   SumMin   = 42'sh200_0000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRESS,
		ST_PN,
		ST_PROD,
		ST_ACC,
		ST_DIV,
		ST_EMIT
	} pct_state_t;

	typedef struct packed {
		logic accept;
		logic press;
		logic pn;
		logic prod;
		logic acc;
		logic div_start;
		logic emit;
	} pct_cmd_t;

	typedef struct packed {
		logic comp_last;
		logic need_div;
		logic div_done;
		logic out_free;
	} pct_sts_t;

endpackage

// ===== hw/rtl/pct_div.sv =====
module pct_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [pct_pkg::SumW-1:0]   dividend,
	input  logic        [pct_pkg::CntW-1:0]   divisor,
	output logic                              done,
	output logic signed [31:0]                quotient
);
	import pct_pkg::*;

	localparam int StepW = $clog2(SumW);

	logic             busy_q;
	logic             done_q;
	logic [StepW-1:0] step_q;
	logic [SumW-1:0]  mag_q;
	logic [CntW-1:0]  rem_q;
	logic             neg_q;

	logic [SumW-1:0]  mag_in;
	logic [CntW:0]    rem_sh;
	logic             fits;
	logic [CntW:0]    rem_sub;

	assign mag_in  = dividend[SumW-1] ? (~dividend + 1'b1) : dividend;
	assign rem_sh  = {rem_q, mag_q[SumW-1]};
	assign fits    = rem_sh >= {1'b0, divisor};
	assign rem_sub = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == StepW'(SumW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag_in;
			rem_q <= '0;
			neg_q <= dividend[SumW-1];
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
			mag_q <= {mag_q[SumW-2:0], fits};
		end
	end

	always_comb begin
		if (!neg_q) begin
			quotient = (|mag_q[SumW-1:31]) ? 32'sh7FFF_FFFF : $signed(mag_q[31:0]);
		end else begin
			quotient = (mag_q > SumW'(64'd2147483648)) ? 32'sh8000_0000
				: $signed(~mag_q[31:0] + 32'd1);
		end
	end

	assign done = done_q;

endmodule

// ===== hw/rtl/pct_ctrl.sv =====
module pct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  pct_pkg::pct_sts_t sts,
	output pct_pkg::pct_cmd_t cmd
);
	import pct_pkg::*;

	pct_state_t state_q;
	pct_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_nx = ST_PRESS;
			end
			ST_PRESS: state_nx = ST_PN;
			ST_PN:    state_nx = ST_PROD;
			ST_PROD:  state_nx = ST_ACC;
			ST_ACC: begin
				if (!sts.comp_last) state_nx = ST_PN;
				else if (sts.need_div) state_nx = ST_DIV;
				else state_nx = ST_EMIT;
			end
			ST_DIV: begin
				if (sts.div_done) state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.accept    = s_axis_tvalid;
			end
			ST_PRESS: cmd.press = 1'b1;
			ST_PN:    cmd.pn    = 1'b1;
			ST_PROD:  cmd.prod  = 1'b1;
			ST_ACC: begin
				cmd.acc       = 1'b1;
				cmd.div_start = sts.comp_last && sts.need_div;
			end
			ST_DIV: begin
			end
			ST_EMIT: cmd.emit = sts.out_free;
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/pct_dp.sv =====
module pct_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pct_pkg::CfgAddrW-1:0]  cfg_addr,
	input  logic [pct_pkg::CfgDataW-1:0]  cfg_wdata,
	input  logic [pct_pkg::InDataW-1:0]   s_axis_tdata,
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [pct_pkg::OutDataW-1:0]  m_axis_tdata,
	output logic                          m_axis_tlast,
	input  pct_pkg::pct_cmd_t             cmd,
	output pct_pkg::pct_sts_t             sts
);
	import pct_pkg::*;

	// Configuration registers.
	logic [31:0]        penalty_q;
	logic [RelaxW-1:0]  relax_q;
	logic signed [31:0] offset_q;

	// Per-point control and pass statistics.
	logic [PtW-1:0]          pt_cnt_q;
	logic [FillW-1:0]        fill_q;
	logic [1:0]              comp_q;
	logic signed [SumW-1:0]  sum_q;
	logic signed [31:0]      min_q;
	logic [CntW-1:0]         count_q;
	logic                    out_vld_q;

	// Item payload.
	logic signed [31:0]       d_q;
	logic signed [15:0]       n_q [3];
	logic                     last_q;
	logic [PtW-1:0]           idx_q;
	logic signed [TractW-1:0] old_q [3];
	logic                     old_vld_q;
	logic                     touch_q;
	logic [47:0]              p_q;
	logic signed [TractW-1:0] trac_q [3];
	logic signed [49:0]       pn_s1;
	logic signed [65:0]       qo_s2;
	logic signed [67:0]       rp_s2;
	logic [OutDataW-1:0]      out_data_q;
	logic                     out_last_q;

	logic signed [TractW-1:0] mem_x [MaxPoints];
	logic signed [TractW-1:0] mem_y [MaxPoints];
	logic signed [TractW-1:0] mem_z [MaxPoints];

	logic                     touch;
	logic [32:0]              diff;
	logic [63:0]              p_prod;
	logic [RelaxW-1:0]        r_fac;
	logic [RelaxW-1:0]        q_fac;
	logic signed [64:0]       pn_prod;
	logic signed [TractW-1:0] old_sel;
	logic signed [65:0]       qo_prod;
	logic signed [67:0]       rp_prod;
	logic signed [67:0]       acc_sum;
	logic signed [51:0]       acc_sh;
	logic signed [TractW-1:0] trac_new;
	logic signed [SumW:0]     sum_ext;
	logic signed [SumW-1:0]   sum_new;
	logic                     need_div;
	logic                     div_done;
	logic signed [31:0]       div_quot;
	logic signed [31:0]       avg;
	logic [PtW-1:0]           pt_next;

	assign touch   = d_q < offset_q;
	assign diff    = {offset_q[31], offset_q} - {d_q[31], d_q};
	assign p_prod  = penalty_q * diff[31:0];
	assign r_fac   = (relax_q > RelaxOne) ? RelaxOne : relax_q;
	assign q_fac   = RelaxOne - r_fac;
	assign pn_prod = $signed({1'b0, p_q}) * n_q[comp_q];
	assign old_sel = old_vld_q ? old_q[comp_q] : '0;
	assign qo_prod = $signed({1'b0, q_fac}) * old_sel;
	assign rp_prod = $signed({1'b0, r_fac}) * pn_s1;
	assign acc_sum = $signed({{2{qo_s2[65]}}, qo_s2}) - rp_s2;
	assign acc_sh  = acc_sum[67:16];

	always_comb begin
		if (acc_sh[51:47] == 5'b00000 || acc_sh[51:47] == 5'b11111) begin
			trac_new = acc_sh[TractW-1:0];
		end else begin
			trac_new = acc_sh[51] ? TractMin : TractMax;
		end
	end

	assign sum_ext = $signed({sum_q[SumW-1], sum_q}) + $signed({{11{d_q[31]}}, d_q});

	always_comb begin
		if (sum_ext[SumW] != sum_ext[SumW-1]) begin
			sum_new = sum_ext[SumW] ? SumMin : SumMax;
		end else begin
			sum_new = sum_ext[SumW-1:0];
		end
	end

	assign need_div = last_q && (count_q != '0);
	assign avg      = need_div ? div_quot : 32'sd0;
	assign pt_next  = (last_q || idx_q == PtW'(MaxPoints - 1)) ? '0 : idx_q + 1'b1;

	pct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			penalty_q <= PenaltyReset;
			relax_q   <= RelaxReset;
			offset_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CfgPenalty: penalty_q <= cfg_wdata;
				CfgRelax:   relax_q   <= cfg_wdata[RelaxW-1:0];
				CfgOffset:  offset_q  <= $signed(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_cnt_q  <= '0;
			fill_q    <= '0;
			comp_q    <= '0;
			sum_q     <= '0;
			min_q     <= '0;
			count_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.press) begin
				comp_q <= '0;
				if (touch) begin
					sum_q <= sum_new;
					if (d_q < min_q) min_q <= d_q;
					if (count_q != CountMax) count_q <= count_q + 1'b1;
				end
			end
			if (cmd.acc) comp_q <= comp_q + 1'b1;
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
				pt_cnt_q  <= pt_next;
				if (FillW'(idx_q) == fill_q) fill_q <= fill_q + 1'b1;
				if (last_q) begin
					sum_q   <= '0;
					min_q   <= '0;
					count_q <= '0;
				end
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			d_q       <= $signed(s_axis_tdata[31:0]);
			n_q[0]    <= $signed(s_axis_tdata[47:32]);
			n_q[1]    <= $signed(s_axis_tdata[63:48]);
			n_q[2]    <= $signed(s_axis_tdata[79:64]);
			last_q    <= s_axis_tlast;
			idx_q     <= pt_cnt_q;
			old_q[0]  <= mem_x[pt_cnt_q];
			old_q[1]  <= mem_y[pt_cnt_q];
			old_q[2]  <= mem_z[pt_cnt_q];
			old_vld_q <= FillW'(pt_cnt_q) < fill_q;
		end
		if (cmd.press) begin
			touch_q <= touch;
			p_q     <= touch ? p_prod[63:16] : '0;
		end
		if (cmd.pn) pn_s1 <= pn_prod[64:15];
		if (cmd.prod) begin
			qo_s2 <= qo_prod;
			rp_s2 <= rp_prod;
		end
		if (cmd.acc) begin
			trac_q[comp_q] <= trac_new;
			case (comp_q)
				2'd0:    mem_x[idx_q] <= trac_new;
				2'd1:    mem_y[idx_q] <= trac_new;
				2'd2:    mem_z[idx_q] <= trac_new;
				default: begin
				end
			endcase
		end
		if (cmd.emit) begin
			out_data_q <= {4'b0000, count_q, avg, min_q, touch_q,
				trac_q[2], trac_q[1], trac_q[0]};
			out_last_q <= last_q;
		end
	end

	assign sts.comp_last = comp_q == 2'd2;
	assign sts.need_div  = need_div;
	assign sts.div_done  = div_done;
	assign sts.out_free  = !out_vld_q || m_axis_tready;

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== hw/rtl/penalty_contact_traction_unit.sv =====
// A point request is taken in the idle state; its result reaches the output register after the
// press step and three rounds of normal product, product and accumulate steps, and when it closes
// a pass with contacts also after the mean has run through a 42-step one-bit-per-cycle divider.
// Points are taken one at a time, the next only once the last result is emitted, as the shared
// multiply path serves the three normal components in turn; a waiting result stalls the next point.
// Reset restores the register defaults and clears the pass statistics; stored traction reads as zero
// until written, tracked by a fill count, so there is no clearing pass.
module penalty_contact_traction_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pct_pkg::CfgAddrW-1:0]  cfg_addr,
	input  logic [pct_pkg::CfgDataW-1:0]  cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// penetration, normal_x, normal_y, normal_z
	input  logic [pct_pkg::InDataW-1:0]   s_axis_tdata,
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// traction_x, traction_y, traction_z, in_contact, min_penetration, avg_penetration,
	// contact_count, four zero bits
	output logic [pct_pkg::OutDataW-1:0]  m_axis_tdata,
	output logic                          m_axis_tlast
);
	import pct_pkg::*;

	pct_cmd_t cmd;
	pct_sts_t sts;

	pct_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	pct_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

// ===== hw/rtl/pct_checker.sv =====
module pct_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [pct_pkg::OutDataW-1:0]  m_axis_tdata,
	input logic                          m_axis_tlast
);

	// A request is followed by a busy period.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_avg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && m_axis_tdata[219:209] == 11'd0
		|-> m_axis_tdata[208:177] == 32'd0)
		else $error("mean given without contacts");

	a_min_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[176] || m_axis_tdata[176:145] == 32'd0)
		else $error("running minimum above zero");

	a_contact_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[144] |-> m_axis_tdata[219:209] != 11'd0)
		else $error("contact point not counted");

endmodule

bind penalty_contact_traction_unit pct_checker u_pct_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import pct_pkg::*;

	localparam int HoldCycles  = 300;
	localparam int DrainCycles = 80;
	localparam int IdlePercent = 27;

	typedef struct packed {
		logic signed [TractW-1:0] tx;
		logic signed [TractW-1:0] ty;
		logic signed [TractW-1:0] tz;
		logic                     in_contact;
		logic                     pass_done;
		logic signed [31:0]       min_pen;
		logic signed [31:0]       avg_pen;
		logic [CntW-1:0]          count;
		logic [3:0]               pad;
	} traction_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CfgAddrW-1:0]   cfg_addr;
	logic [CfgDataW-1:0]   cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [InDataW-1:0]    s_axis_tdata;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OutDataW-1:0]   m_axis_tdata;
	logic                  m_axis_tlast;

	logic calm = 1'b0;
	int   hold_gen = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   fail_count = 0;

	traction_result_t pending_tractions [$];

	logic [31:0]              penalty_q;
	logic [RelaxW-1:0]        relax_q;
	logic signed [31:0]       offset_q;
	logic signed [TractW-1:0] traction_mem [3][MaxPoints];
	logic [PtW-1:0]           point_idx;
	longint                   pen_sum;
	logic signed [31:0]       pass_min;
	logic [CntW-1:0]          touch_total;

	penalty_contact_traction_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic traction_result_t predict_traction(input logic signed [31:0] pen,
			input logic signed [15:0] nx, input logic signed [15:0] ny,
			input logic signed [15:0] nz, input logic last);
		traction_result_t    res;
		logic signed [127:0] gap, pressure, pn, keep_w, relax_w, old_v, mix;
		logic signed [15:0]  nrm [3];
		logic signed [TractW-1:0] newv [3];
		longint              cnt_l, mean;
		logic                touch;
		nrm[0] = nx;
		nrm[1] = ny;
		nrm[2] = nz;
		touch = pen < offset_q;
		pressure = 0;
		if (touch) begin
			gap = offset_q - pen;
			pressure = ($signed({96'd0, penalty_q}) * gap) >>> 16;
			pen_sum = pen_sum + pen;
			if (pen_sum > SumMax) pen_sum = SumMax;
			if (pen_sum < SumMin) pen_sum = SumMin;
			if (pen < pass_min) pass_min = pen;
			if (touch_total != CountMax) touch_total = touch_total + 1'b1;
		end
		relax_w = (relax_q > RelaxOne) ? RelaxOne : relax_q;
		keep_w = 65536 - relax_w;
		for (int i = 0; i < 3; i++) begin
			old_v = traction_mem[i][point_idx];
			pn = (pressure * nrm[i]) >>> 15;
			mix = (keep_w * old_v - relax_w * pn) >>> 16;
			if (mix > TractMax) mix = TractMax;
			if (mix < TractMin) mix = TractMin;
			newv[i] = mix[TractW-1:0];
			traction_mem[i][point_idx] = newv[i];
		end
		mean = 0;
		if (last && touch_total != 0) begin
			cnt_l = touch_total;
			mean = pen_sum / cnt_l;
			if (mean > 64'sd2147483647) mean = 64'sd2147483647;
			if (mean < -64'sd2147483648) mean = -64'sd2147483648;
		end
		res.tx = newv[0];
		res.ty = newv[1];
		res.tz = newv[2];
		res.in_contact = touch;
		res.pass_done = last;
		res.min_pen = pass_min;
		res.avg_pen = 32'(mean);
		res.count = touch_total;
		res.pad = '0;
		point_idx = point_idx + 1'b1;
		if (last) begin
			point_idx = '0;
			pen_sum = 0;
			pass_min = '0;
			touch_total = '0;
		end
		return res;
	endfunction

	task automatic compare_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// The receiver either follows its random pattern or sits out a long hold-off.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_gen != hold_seen) begin
			hold_seen <= hold_gen;
			hold_left <= HoldCycles;
			m_axis_tready <= 1'b0;
		end else if (calm) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= IdlePercent);
		end
	end

	always @(posedge clk) begin : check_result
		traction_result_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.tx = m_axis_tdata[47:0];
			got.ty = m_axis_tdata[95:48];
			got.tz = m_axis_tdata[143:96];
			got.in_contact = m_axis_tdata[144];
			got.min_pen = m_axis_tdata[176:145];
			got.avg_pen = m_axis_tdata[208:177];
			got.count = m_axis_tdata[219:209];
			got.pad = m_axis_tdata[223:220];
			got.pass_done = m_axis_tlast;
			if (pending_tractions.size() == 0) begin
				$error("Result arrived with no point request outstanding");
				fail_count++;
			end else begin
				want = pending_tractions.pop_front();
				compare_field("traction_x", want.tx, got.tx);
				compare_field("traction_y", want.ty, got.ty);
				compare_field("traction_z", want.tz, got.tz);
				compare_field("in_contact", want.in_contact, got.in_contact);
				compare_field("pass_done", want.pass_done, got.pass_done);
				compare_field("min_penetration", want.min_pen, got.min_pen);
				compare_field("avg_penetration", want.avg_pen, got.avg_pen);
				compare_field("contact_count", want.count, got.count);
				compare_field("padding", want.pad, got.pad);
			end
		end
	end

	task automatic send_point(input logic signed [31:0] pen, input logic signed [15:0] nx,
			input logic signed [15:0] ny, input logic signed [15:0] nz, input logic last);
		while (!calm && $urandom_range(99) < IdlePercent) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {nz, ny, nx, pen};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		pending_tractions.push_back(predict_traction(pen, nx, ny, nz, last));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_tractions.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CfgPenalty: penalty_q = value;
			CfgRelax:   relax_q = value[RelaxW-1:0];
			CfgOffset:  offset_q = value;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [31:0] penalty, input logic [31:0] relax,
			input logic [31:0] offset);
		write_reg(CfgPenalty, penalty);
		write_reg(CfgRelax, relax);
		write_reg(CfgOffset, offset);
	endtask

	function automatic logic signed [15:0] pick_normal();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return $urandom_range(1) ? 16'sh0000 : 16'shFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_penetration();
		case ($urandom_range(5))
			0: return offset_q - $urandom_range(1, 4096);
			1: return offset_q + $urandom_range(0, 4096);
			2: return offset_q - ($urandom >> $urandom_range(31));
			3: begin
				case ($urandom_range(3))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return offset_q;
					default: return offset_q - 1;
				endcase
			end
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_penalty();
		case ($urandom_range(4))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return PenaltyReset;
			3: return $urandom;
			default: return $urandom_range(1 << 20);
		endcase
	endfunction

	function automatic logic [31:0] pick_relax();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return RelaxOne;
			2: return RelaxReset;
			3: return $urandom_range(65536);
			4: return $urandom_range(65537, 131071);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_offset();
		case ($urandom_range(4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'd0;
			3: return $urandom;
			default: return $urandom_range(1 << 20) - (1 << 19);
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_point(-32'sd65536, 16'sd0, 16'sd0, 16'sh7FFF, 1'b0);
		send_point(32'sd65536, 16'sh7FFF, 16'sd0, 16'sd0, 1'b0);
		send_point(32'sd0, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
		send_point(-32'sd1, 16'sd12345, -16'sd23456, 16'sd1, 1'b1);
	endtask

	task automatic test_saturation_extremes();
		wait_drained();
		set_config(32'hFFFF_FFFF, RelaxOne, 32'h7FFF_FFFF);
		send_point(32'sh8000_0000, 16'sh8000, 16'sh7FFF, 16'sd0, 1'b0);
		send_point(32'sh8000_0000, 16'sh7FFF, 16'sh8000, -16'sd1, 1'b1);
		// Relax weights above one act as one; the upper data bits must be dropped.
		wait_drained();
		write_reg(CfgRelax, 32'hFFFF_FFFF);
		send_point(32'sh7FFF_FFFF, 16'sh4000, -16'sh4000, 16'sh7FFF, 1'b0);
		send_point(32'sh8000_0000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
		// Zero relax keeps the stored traction; no point can lie below the lowest offset.
		wait_drained();
		set_config(32'd0, 32'd0, 32'h8000_0000);
		send_point(32'sh8000_0000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
		send_point(32'sh7FFF_FFFF, 16'sd0, 16'sd0, 16'sd0, 1'b1);
		wait_drained();
		set_config(32'd1, 32'd65537, 32'd0);
		send_point(-32'sd1, 16'sh7FFF, 16'sh8000, 16'sd1, 1'b0);
		send_point(32'sh8000_0000, 16'sh8000, 16'sd0, 16'sh7FFF, 1'b1);
	endtask

	task automatic test_pass_statistics();
		wait_drained();
		set_config(PenaltyReset, RelaxReset, 32'd0);
		send_point(-32'sd5, 16'sd100, 16'sd200, 16'sd300, 1'b0);
		send_point(32'sd7, 16'sd100, 16'sd200, 16'sd300, 1'b0);
		send_point(-32'sd10, -16'sd100, 16'sd0, 16'sd300, 1'b0);
		send_point(-32'sd4, 16'sd0, 16'sd0, 16'sh7FFF, 1'b1);
		send_point(32'sd3, 16'sd9, 16'sd9, 16'sd9, 1'b1);
	endtask

	// One longer pass, mostly at the deepest penetration.
	task automatic test_long_pass();
		wait_drained();
		set_config($urandom_range(1 << 16), $urandom_range(65536), 32'd0);
		for (int k = 0; k < 100; k++)
			send_point((k % 50 == 7) ? pick_penetration() : 32'sh8000_0000, pick_normal(),
				pick_normal(), pick_normal(), k == 99);
	endtask

	task automatic test_random_passes();
		int sent;
		int phase;
		int len;
		sent = 0;
		phase = 0;
		while (sent < 280 || phase < 5) begin
			wait_drained();
			set_config(pick_penalty(), pick_relax(), pick_offset());
			calm <= (phase == 2);
			for (int p = 0; p < 4; p++) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
				if (phase == 3 && p == 1)
					len = 30;
				for (int k = 0; k < len; k++) begin
					if (phase == 3 && p == 1 && k == 0)
						hold_gen <= hold_gen + 1;
					if (phase == 4 && p == 1 && k == len / 2)
						wait_drained();
					send_point(pick_penetration(), pick_normal(), pick_normal(), pick_normal(),
						k == len - 1);
					sent++;
				end
			end
			phase++;
		end
		calm <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		penalty_q = PenaltyReset;
		relax_q = RelaxReset;
		offset_q = '0;
		point_idx = '0;
		pen_sum = 0;
		pass_min = '0;
		touch_total = '0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < MaxPoints; j++)
				traction_mem[i][j] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_saturation_extremes();
		test_pass_statistics();
		test_long_pass();
		test_random_passes();
		wait_drained();
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
